// ----- hw/rtl/osfp_pkg.sv -----
// Package: constants, result type and helpers for the option symbol field parser.
`timescale 1ns / 1ps
package osfp_pkg;

  localparam int MAX_LEN_DEF   = 32;
  localparam int UNDER_CAP_DEF = 8;

  localparam int CHAR_W   = 8;
  localparam int TEXT_W   = 56;
  localparam int ULEN_W   = 3;
  localparam int DATE_W   = 7;
  localparam int STRIKE_W = 27;
  localparam int DIGIT_W  = 4;
  localparam int WIN_LEN  = 8;
  localparam int DATE_LEN = 6;

  localparam logic [CHAR_W-1:0] ASCII_0 = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_9 = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_C = 8'h43;
  localparam logic [CHAR_W-1:0] ASCII_P = 8'h50;

  localparam int MIN_TAIL      = 15;
  localparam int STRIKE_DIGITS = 8;

  typedef struct packed {
    logic                valid_res;
    logic [TEXT_W-1:0]   underlying_text;
    logic [ULEN_W-1:0]   under_len;
    logic [DATE_W-1:0]   year;
    logic [DATE_W-1:0]   month;
    logic [DATE_W-1:0]   day;
    logic                is_call;
    logic [STRIKE_W-1:0] strike_milli;
  } osfp_res_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= ASCII_0) && (c <= ASCII_9);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_val(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = c - ASCII_0;
    return d[DIGIT_W-1:0];
  endfunction

  // two decimal digits to their value
  function automatic logic [DATE_W-1:0] two_digits(input logic [DIGIT_W-1:0] hi,
                                                   input logic [DIGIT_W-1:0] lo);
    return DATE_W'(hi) * DATE_W'(10) + DATE_W'(lo);
  endfunction

endpackage

// ----- hw/rtl/osfp_in_if.sv -----
// Character input channel: valid/ready with one symbol character per transfer.
`timescale 1ns / 1ps
interface osfp_in_if
  import osfp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, char_code, is_last, input ready);
  modport sink   (input valid, char_code, is_last, output ready);
endinterface

// ----- hw/rtl/osfp_out_if.sv -----
// Result output channel: valid/ready with the decoded symbol fields.
`timescale 1ns / 1ps
interface osfp_out_if
  import osfp_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                valid_res;
  logic [TEXT_W-1:0]   underlying_text;
  logic [ULEN_W-1:0]   under_len;
  logic [DATE_W-1:0]   year;
  logic [DATE_W-1:0]   month;
  logic [DATE_W-1:0]   day;
  logic                is_call;
  logic [STRIKE_W-1:0] strike_milli;

  modport source (output valid, valid_res, underlying_text, under_len, year, month, day,
                  is_call, strike_milli, input ready);
  modport sink   (input valid, valid_res, underlying_text, under_len, year, month, day,
                  is_call, strike_milli, output ready);
endinterface

// ----- hw/rtl/option_symbol_field_parser.sv -----
// Streaming option symbol parser: window match, field capture, result register with skid.
// The result of a symbol is registered when its last character is accepted.
// Throughput: one character per cycle unless ready is low; each updates the parse state.
// The output register plus a one-entry skid stage let characters keep flowing while a
// result waits; input ready drops only when both the output and the skid entry are full.
// Reset (rst, synchronous, active high) clears the parse state and empties the output.
`timescale 1ns / 1ps
module option_symbol_field_parser
  import osfp_pkg::*;
#(
  parameter int MAX_LEN   = MAX_LEN_DEF,
  parameter int UNDER_CAP = UNDER_CAP_DEF
) (
  input logic        clk,
  input logic        rst,
  osfp_in_if.sink    in_ch,
  osfp_out_if.source out_ch
);

  localparam int CNT_W      = $clog2(MAX_LEN + 1);
  localparam int HEAD_DEPTH = UNDER_CAP - 1;
  localparam int SCNT_W     = $clog2(STRIKE_DIGITS + 1);

  // parse state
  logic [WIN_LEN-1:0][CHAR_W-1:0]      window;
  logic [HEAD_DEPTH-1:0][CHAR_W-1:0]   head;
  logic [CNT_W-1:0]                    char_count;
  logic                                len_over;
  logic                                match_found;
  logic [CNT_W-1:0]                    match_pos;
  logic [DATE_LEN-1:0][DIGIT_W-1:0]    date_digits;
  logic                                type_call;
  logic [STRIKE_W-1:0]                 strike_acc;
  logic [SCNT_W-1:0]                   strike_cnt;
  logic                                strike_stopped;

  logic [WIN_LEN-1:0][CHAR_W-1:0]      window_next;
  logic [CNT_W-1:0]                    char_count_next;
  logic                                len_over_next;
  logic                                match_found_next;
  logic [CNT_W-1:0]                    match_pos_next;
  logic [DATE_LEN-1:0][DIGIT_W-1:0]    date_digits_next;
  logic                                type_call_next;
  logic [STRIKE_W-1:0]                 strike_acc_next;
  logic [SCNT_W-1:0]                   strike_cnt_next;
  logic                                strike_stopped_next;

  // output stage
  osfp_res_t out_res, skid_res, res_new;
  logic      out_v, skid_v;

  logic              accept, take, hit;
  logic [CHAR_W-1:0] c;
  logic [ULEN_W-1:0] ulen;
  logic              res_ok;
  logic              out_free;

  assign c        = in_ch.char_code;
  assign in_ch.ready = !skid_v;
  assign accept   = in_ch.valid && in_ch.ready;
  assign take     = char_count < CNT_W'(MAX_LEN);
  assign out_free = !out_v || out_ch.ready;

  always_comb begin
    for (int k = 0; k < WIN_LEN - 1; k++) begin
      window_next[k] = window[k + 1];
    end
    window_next[WIN_LEN-1] = c;

    hit = (char_count >= CNT_W'(WIN_LEN));
    for (int k = 0; k < DATE_LEN; k++) begin
      if (!is_digit(window_next[k])) hit = 1'b0;
    end
    if (window_next[DATE_LEN] != ASCII_C && window_next[DATE_LEN] != ASCII_P) hit = 1'b0;
    if (!is_digit(window_next[WIN_LEN-1])) hit = 1'b0;

    char_count_next     = char_count;
    len_over_next       = len_over || !take;
    match_found_next    = match_found;
    match_pos_next      = match_pos;
    date_digits_next    = date_digits;
    type_call_next      = type_call;
    strike_acc_next     = strike_acc;
    strike_cnt_next     = strike_cnt;
    strike_stopped_next = strike_stopped;

    if (take) begin
      char_count_next = char_count + CNT_W'(1);
      if (match_found) begin
        if (!strike_stopped && strike_cnt < SCNT_W'(STRIKE_DIGITS)) begin
          if (is_digit(c)) begin
            strike_acc_next = strike_acc * STRIKE_W'(10) + STRIKE_W'(digit_val(c));
            strike_cnt_next = strike_cnt + SCNT_W'(1);
          end else begin
            strike_stopped_next = 1'b1;
          end
        end
      end else if (hit) begin
        match_found_next = 1'b1;
        match_pos_next   = char_count - CNT_W'(WIN_LEN - 1);
        for (int k = 0; k < DATE_LEN; k++) begin
          date_digits_next[k] = digit_val(window_next[k]);
        end
        type_call_next      = (window_next[DATE_LEN] == ASCII_C);
        strike_acc_next     = STRIKE_W'(digit_val(c));
        strike_cnt_next     = SCNT_W'(1);
        strike_stopped_next = 1'b0;
      end
    end

    res_ok = match_found_next && !len_over_next &&
             ({1'b0, char_count_next} >= {1'b0, match_pos_next} + (CNT_W + 1)'(MIN_TAIL));

    if (match_pos_next > CNT_W'(HEAD_DEPTH)) begin
      ulen = ULEN_W'(HEAD_DEPTH);
    end else begin
      ulen = match_pos_next[ULEN_W-1:0];
    end

    res_new = '0;
    if (res_ok) begin
      res_new.valid_res = 1'b1;
      res_new.under_len = ulen;
      for (int k = 0; k < HEAD_DEPTH; k++) begin
        if (ULEN_W'(k) < ulen) res_new.underlying_text[8*k +: 8] = head[k];
      end
      res_new.year         = two_digits(date_digits_next[0], date_digits_next[1]);
      res_new.month        = two_digits(date_digits_next[2], date_digits_next[3]);
      res_new.day          = two_digits(date_digits_next[4], date_digits_next[5]);
      res_new.is_call      = type_call_next;
      res_new.strike_milli = strike_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count     <= '0;
      len_over       <= 1'b0;
      match_found    <= 1'b0;
      strike_cnt     <= '0;
      strike_stopped <= 1'b0;
      out_v          <= 1'b0;
      skid_v         <= 1'b0;
    end else begin
      if (accept) begin
        if (in_ch.is_last) begin
          // symbol done: back to the idle parse state
          char_count     <= '0;
          len_over       <= 1'b0;
          match_found    <= 1'b0;
          strike_cnt     <= '0;
          strike_stopped <= 1'b0;
        end else begin
          char_count     <= char_count_next;
          len_over       <= len_over_next;
          match_found    <= match_found_next;
          strike_cnt     <= strike_cnt_next;
          strike_stopped <= strike_stopped_next;
        end
      end

      if (out_free) begin
        if (skid_v) begin
          out_v  <= 1'b1;
          skid_v <= 1'b0;
        end else begin
          out_v <= accept && in_ch.is_last;
        end
      end else if (accept && in_ch.is_last) begin
        skid_v <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && take) begin
      window <= window_next;
      for (int k = 0; k < HEAD_DEPTH; k++) begin
        if (char_count == CNT_W'(k)) head[k] <= c;
      end
    end
    if (accept) begin
      match_pos   <= match_pos_next;
      date_digits <= date_digits_next;
      type_call   <= type_call_next;
      strike_acc  <= strike_acc_next;
    end
    if (out_free) begin
      if (skid_v) begin
        out_res <= skid_res;
      end else begin
        out_res <= res_new;
      end
    end else if (accept && in_ch.is_last) begin
      skid_res <= res_new;
    end
  end

  assign out_ch.valid           = out_v;
  assign out_ch.valid_res       = out_res.valid_res;
  assign out_ch.underlying_text = out_res.underlying_text;
  assign out_ch.under_len       = out_res.under_len;
  assign out_ch.year            = out_res.year;
  assign out_ch.month           = out_res.month;
  assign out_ch.day             = out_res.day;
  assign out_ch.is_call         = out_res.is_call;
  assign out_ch.strike_milli    = out_res.strike_milli;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid entry held while output register empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= CNT_W'(MAX_LEN))
    else $error("character count beyond maximum length");

  a_match_pos: assert property (@(posedge clk) disable iff (rst)
    match_found |-> (match_pos >= CNT_W'(1)) &&
                    ({1'b0, match_pos} + (CNT_W + 1)'(WIN_LEN) <= {1'b0, char_count}))
    else $error("match position inconsistent with character count");

  a_strike_len: assert property (@(posedge clk) disable iff (rst)
    strike_cnt <= SCNT_W'(STRIKE_DIGITS))
    else $error("strike digit count overrun");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_v && !out_res.valid_res) |->
      (out_res.strike_milli == '0) && (out_res.under_len == '0) &&
      (out_res.underlying_text == '0) && (out_res.year == '0) && !out_res.is_call)
    else $error("invalid result carries nonzero fields");

endmodule

// ----- dv/option_symbol_field_parser_tb.sv -----
// Testbench for the option symbol field parser: random symbols, local decoder, field checks.
`timescale 1ns / 1ps
module option_symbol_field_parser_tb;
  import osfp_pkg::*;

  localparam int FEED_GOAL    = 550;
  localparam int SYMBOL_GOAL  = 20;
  localparam int HOLD_CYCLES  = 60;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_item_t;

  logic clk;
  logic rst;

  osfp_in_if  in_bus ();
  osfp_out_if out_bus ();

  option_symbol_field_parser DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  char_item_t feed_q[$];
  osfp_res_t  pending_fields[$];
  char_item_t next_item;
  osfp_res_t  want;
  int         fed_n;
  int         total_items;
  int         symbol_n;
  int         errors;
  int         hold_left;
  int         stall_cycles;

  // local copy of the parse state
  logic [CHAR_W-1:0]   win [WIN_LEN];
  logic [CHAR_W-1:0]   head [7];
  logic [DIGIT_W-1:0]  date_d [DATE_LEN];
  int unsigned         sym_len;
  int unsigned         match_at;
  logic                matched;
  logic                call_flag;
  logic [STRIKE_W-1:0] strike;
  int unsigned         strike_n;
  logic                strike_done;
  logic                too_long;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic numeric(input logic [CHAR_W-1:0] c);
    return c >= ASCII_0 && c <= ASCII_9;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    return ASCII_0 + CHAR_W'($urandom_range(0, 9));
  endfunction

  task automatic clear_parse();
    for (int k = 0; k < WIN_LEN; k++) win[k] = '0;
    for (int k = 0; k < 7; k++) head[k] = '0;
    for (int k = 0; k < DATE_LEN; k++) date_d[k] = '0;
    sym_len     = 0;
    match_at    = 0;
    matched     = 1'b0;
    call_flag   = 1'b0;
    strike      = '0;
    strike_n    = 0;
    strike_done = 1'b0;
    too_long    = 1'b0;
  endtask

  task automatic decode_char(input logic [CHAR_W-1:0] c, input logic last);
    osfp_res_t   r;
    int unsigned p;
    int unsigned ulen;
    logic        hit;
    p = sym_len;
    if (p >= MAX_LEN_DEF) begin
      too_long = 1'b1;
    end else begin
      sym_len = p + 1;
      for (int k = 0; k < WIN_LEN - 1; k++) win[k] = win[k + 1];
      win[WIN_LEN - 1] = c;
      if (p < UNDER_CAP_DEF - 1 && p < 7) head[p] = c;
      if (matched) begin
        if (!strike_done && strike_n < STRIKE_DIGITS) begin
          if (numeric(c)) begin
            strike   = strike * 10 + STRIKE_W'(c - ASCII_0);
            strike_n = strike_n + 1;
          end else begin
            strike_done = 1'b1;
          end
        end
      end else if (p >= WIN_LEN) begin
        hit = 1'b1;
        for (int k = 0; k < DATE_LEN; k++) if (!numeric(win[k])) hit = 1'b0;
        if (win[6] != ASCII_C && win[6] != ASCII_P) hit = 1'b0;
        if (!numeric(win[7])) hit = 1'b0;
        if (hit) begin
          matched  = 1'b1;
          match_at = p - 7;
          for (int k = 0; k < DATE_LEN; k++) date_d[k] = DIGIT_W'(win[k] - ASCII_0);
          call_flag   = (win[6] == ASCII_C);
          strike      = STRIKE_W'(win[7] - ASCII_0);
          strike_n    = 1;
          strike_done = 1'b0;
        end
      end
    end
    if (last) begin
      r = '0;
      if (matched && !too_long && sym_len >= match_at + MIN_TAIL) begin
        ulen = (match_at > UNDER_CAP_DEF - 1) ? UNDER_CAP_DEF - 1 : match_at;
        if (ulen > 7) ulen = 7;
        for (int k = 0; k < ulen; k++) r.underlying_text[8*k +: 8] = head[k];
        r.valid_res      = 1'b1;
        r.under_len      = ULEN_W'(ulen);
        r.year           = DATE_W'(date_d[0]) * 10 + DATE_W'(date_d[1]);
        r.month          = DATE_W'(date_d[2]) * 10 + DATE_W'(date_d[3]);
        r.day            = DATE_W'(date_d[4]) * 10 + DATE_W'(date_d[5]);
        r.is_call        = call_flag;
        r.strike_milli   = strike;
      end
      pending_fields.push_back(r);
      clear_parse();
    end
  endtask

  task automatic push_symbol(input logic [CHAR_W-1:0] s[$]);
    char_item_t it;
    foreach (s[k]) begin
      it.code = s[k];
      it.last = (k == s.size() - 1);
      feed_q.push_back(it);
    end
    symbol_n++;
  endtask

  task automatic push_text(input string txt);
    logic [CHAR_W-1:0] s[$];
    for (int k = 0; k < txt.len(); k++) s.push_back(txt[k]);
    push_symbol(s);
  endtask

  task automatic push_filler(ref logic [CHAR_W-1:0] s[$], input int n);
    for (int k = 0; k < n; k++)
      s.push_back($urandom_range(0, 1) ? rand_digit() : CHAR_W'($urandom_range(1, 255)));
  endtask

  // Mostly well-formed symbols; some truncated, overlong, corrupted or pure noise.
  task automatic queue_random_symbol();
    logic [CHAR_W-1:0] s[$];
    int kind;
    int pos;
    int ndig;
    int nsuf;
    int target;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      for (int k = $urandom_range(1, 20); k > 0; k--)
        s.push_back(($urandom_range(0, 3) == 0) ? rand_digit() : CHAR_W'($urandom_range(1, 255)));
    end else begin
      pos = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 17);
      for (int k = 0; k < pos; k++)
        s.push_back(($urandom_range(0, 4) == 0) ? CHAR_W'($urandom_range(1, 255))
                                                : CHAR_W'("A") + CHAR_W'($urandom_range(0, 25)));
      for (int k = 0; k < DATE_LEN; k++) s.push_back(rand_digit());
      s.push_back($urandom_range(0, 1) ? ASCII_C : ASCII_P);
      if (kind >= 55 && kind < 68) begin
        // too few characters after the match start
        ndig = $urandom_range(1, 7);
        nsuf = $urandom_range(0, 7 - ndig);
      end else begin
        ndig = $urandom_range(1, 10);
        nsuf = (ndig >= 8) ? $urandom_range(0, 3) : $urandom_range(8 - ndig, 11 - ndig);
      end
      for (int k = 0; k < ndig; k++) s.push_back(rand_digit());
      if (kind >= 68 && kind < 78) begin
        target = $urandom_range(MAX_LEN_DEF + 1, MAX_LEN_DEF + 8);
        nsuf   = (target > s.size()) ? target - s.size() : $urandom_range(0, 3);
      end
      push_filler(s, nsuf);
      if (kind >= 78) s[$urandom_range(0, s.size() - 1)] = CHAR_W'($urandom_range(1, 255));
    end
    push_symbol(s);
  endtask

  // phases by accepted characters: none, sender idle, receiver stall, both light
  function automatic int idle_pct(input logic rx_side);
    case ((fed_n / 64) % 4)
      1: return rx_side ? 0 : 63;
      2: return rx_side ? 63 : 0;
      3: return 11;
      default: return 0;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] exp_v);
    if (errors < PRINT_CAP)
      $display("%0t: mismatch in %s: got %0h, want %0h", $realtime, what, got, exp_v);
    errors++;
  endtask

  // character driver
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid     <= 1'b0;
      in_bus.char_code <= '0;
      in_bus.is_last   <= 1'b0;
      fed_n            <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        decode_char(in_bus.char_code, in_bus.is_last);
        fed_n <= fed_n + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (feed_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          next_item         = feed_q.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.char_code <= next_item.code;
          in_bus.is_last   <= next_item.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result ready; long hold-off right after reset so the skid fills and input stalls
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (pending_fields.size() == 0) begin
        note_mismatch("unexpected result", 64'(out_bus.strike_milli), '0);
      end else begin
        want = pending_fields.pop_front();
        if (out_bus.valid_res !== want.valid_res)
          note_mismatch("valid_res", 64'(out_bus.valid_res), 64'(want.valid_res));
        if (out_bus.underlying_text !== want.underlying_text)
          note_mismatch("underlying_text", 64'(out_bus.underlying_text),
                        64'(want.underlying_text));
        if (out_bus.under_len !== want.under_len)
          note_mismatch("under_len", 64'(out_bus.under_len), 64'(want.under_len));
        if (out_bus.year !== want.year)
          note_mismatch("year", 64'(out_bus.year), 64'(want.year));
        if (out_bus.month !== want.month)
          note_mismatch("month", 64'(out_bus.month), 64'(want.month));
        if (out_bus.day !== want.day)
          note_mismatch("day", 64'(out_bus.day), 64'(want.day));
        if (out_bus.is_call !== want.is_call)
          note_mismatch("is_call", 64'(out_bus.is_call), 64'(want.is_call));
        if (out_bus.strike_milli !== want.strike_milli)
          note_mismatch("strike_milli", 64'(out_bus.strike_milli), 64'(want.strike_milli));
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst      = 1'b1;
    symbol_n = 0;
    clear_parse();

    // extremes of the character code, digit edges, a date and type at position zero that is
    // never matched, full eight-digit strike with an extra digit that is dropped
    push_text("\001");
    push_text("\377");
    push_text("/");
    push_text(":");
    push_text("250801C1");
    push_text("Q250801C123456789");
    while (feed_q.size() < FEED_GOAL || symbol_n < SYMBOL_GOAL) queue_random_symbol();
    total_items = feed_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (fed_n < total_items || pending_fields.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
